>>> src/ffbt_pkg.sv
// shared constants, types and command/status bundles of the boundary-tag allocator
package ffbt_pkg;

    localparam int POOL_WORDS = 256;
    localparam int AW         = $clog2(POOL_WORDS);
    localparam int TW         = AW + 1;
    localparam int LEN_W      = 8;
    localparam int PIDX_W     = 8;
    localparam int CW         = (AW + 2 > LEN_W + 2) ? AW + 2 : LEN_W + 2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_W0,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_F_START,
        S_F_HD,
        S_F_NRD,
        S_F_NCHK,
        S_F_PRD,
        S_F_PCHK,
        S_F_W0,
        S_F_W1,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_LOC,
        RD_HEAD,
        RD_NEXT,
        RD_PREV
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_CLR,
        WR_A_HDR,
        WR_A_FTR,
        WR_R_HDR,
        WR_R_FTR,
        WR_F_HDR,
        WR_F_FTR
    } t_wr_sel;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    clr_step;
        logic    walk_step;
        logic    ld_size;
        logic    ld_free;
        logic    add_next;
        logic    add_prev;
        logic    set_fail;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic in_free;
        logic clr_done;
        logic loc_end;
        logic tag_zero;
        logic fits;
        logic over;
        logic addr_bad;
        logic head_bad;
        logic has_next;
        logic next_ok;
        logic has_prev;
        logic prev_ok;
        logic out_free;
    } t_status;

endpackage

>>> src/ffbt_ram.sv
// generic single write port, single read port ram with registered read
module ffbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ffbt_ctrl.sv
// controller state machine sequencing clear, allocate walk and free merge
module ffbt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ffbt_pkg::t_status i_status,
    output logic             o_in_ready,
    output ffbt_pkg::t_cmd   o_cmd
);
    import ffbt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_status.in_free ? S_F_START : S_A_RD;
            end
            S_A_RD: begin
                n_state = i_status.loc_end ? S_DONE : S_A_CHK;
            end
            S_A_CHK: begin
                if (i_status.tag_zero) begin
                    n_state = S_DONE;
                end else if (i_status.fits) begin
                    n_state = i_status.over ? S_DONE : S_A_W0;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_W0:    n_state = S_A_W1;
            S_A_W1:    n_state = S_A_W2;
            S_A_W2:    n_state = S_A_W3;
            S_A_W3:    n_state = S_DONE;
            S_F_START: n_state = i_status.addr_bad ? S_DONE : S_F_HD;
            S_F_HD:    n_state = i_status.head_bad ? S_DONE : S_F_NRD;
            S_F_NRD:   n_state = i_status.has_next ? S_F_NCHK : S_F_PRD;
            S_F_NCHK:  n_state = S_F_PRD;
            S_F_PRD:   n_state = i_status.has_prev ? S_F_PCHK : S_F_W0;
            S_F_PCHK:  n_state = S_F_W0;
            S_F_W0:    n_state = S_F_W1;
            S_F_W1:    n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_CLR;
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_A_RD: begin
                if (i_status.loc_end) begin
                    o_cmd.set_fail = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LOC;
                end
            end
            S_A_CHK: begin
                if (i_status.tag_zero) begin
                    o_cmd.set_fail = 1'b1;
                end else if (i_status.fits) begin
                    if (i_status.over) o_cmd.set_fail = 1'b1;
                    else               o_cmd.ld_size  = 1'b1;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_A_W0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_A_HDR;
            end
            S_A_W1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_A_FTR;
            end
            S_A_W2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_R_HDR;
            end
            S_A_W3: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_R_FTR;
            end
            S_F_START: begin
                if (!i_status.addr_bad) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HEAD;
                end
            end
            S_F_HD: begin
                o_cmd.ld_free = !i_status.head_bad;
            end
            S_F_NRD: begin
                if (i_status.has_next) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            S_F_NCHK: begin
                o_cmd.add_next = i_status.next_ok;
            end
            S_F_PRD: begin
                if (i_status.has_prev) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                end
            end
            S_F_PCHK: begin
                o_cmd.add_prev = i_status.prev_ok;
            end
            S_F_W0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_F_HDR;
            end
            S_F_W1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_F_FTR;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> src/ffbt_dp.sv
// datapath: walk and merge registers, tag pool ram, result register
module ffbt_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ffbt_pkg::t_cmd            i_cmd,
    input  logic                      i_req_type,
    input  logic [ffbt_pkg::LEN_W-1:0] i_alloc_len,
    input  logic [ffbt_pkg::LEN_W-1:0] i_free_addr,
    input  logic                      i_out_ready,
    output ffbt_pkg::t_status         o_status,
    output logic                      o_out_valid,
    output logic [ffbt_pkg::PIDX_W-1:0] o_payload_index,
    output logic                      o_out_status
);
    import ffbt_pkg::*;

    localparam logic [CW-1:0] POOL_C = CW'(POOL_WORDS);

    logic              r_req;
    logic              r_fail;
    logic [CW-1:0]     r_loc;
    logic [CW-1:0]     r_head;
    logic [CW-1:0]     r_need;
    logic [CW-1:0]     r_size;
    logic [AW-1:0]     r_clr;
    logic              r_out_valid;
    logic [PIDX_W-1:0] r_pidx;
    logic              r_stat;

    logic [TW-1:0]     rdata;
    logic [CW-1:0]     size_rd;
    logic              free_rd;
    logic [CW-1:0]     head_end;
    logic [CW-1:0]     rnd_len;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [TW-1:0]     wdata;
    logic [AW-1:0]     raddr;
    logic [CW-1:0]     rem;

    assign size_rd  = CW'({rdata[TW-1:1], 1'b0});
    assign free_rd  = !rdata[0];
    assign head_end = r_head + r_size;
    assign rnd_len  = (CW'(i_alloc_len) + CW'(3)) & ~CW'(3);
    assign rem      = r_size - r_need;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LOC:  raddr = r_loc[AW-1:0];
            RD_HEAD: raddr = r_head[AW-1:0];
            RD_NEXT: raddr = head_end[AW-1:0];
            RD_PREV: raddr = AW'(r_head - CW'(1));
            default: raddr = r_loc[AW-1:0];
        endcase
    end

    always_comb begin
        we = i_cmd.wr_en;
        case (i_cmd.wr_sel)
            WR_CLR: begin
                waddr = r_clr;
                wdata = (r_clr == '0 || r_clr == AW'(POOL_WORDS - 1))
                      ? TW'(POOL_WORDS) : '0;
            end
            WR_A_HDR: begin
                waddr = r_loc[AW-1:0];
                wdata = TW'(r_need) | TW'(1);
            end
            WR_A_FTR: begin
                waddr = AW'(r_loc + r_need - CW'(1));
                wdata = TW'(r_need) | TW'(1);
            end
            WR_R_HDR: begin
                waddr = AW'(r_loc + r_need);
                wdata = TW'(rem);
            end
            WR_R_FTR: begin
                waddr = AW'(r_loc + r_size - CW'(1));
                wdata = TW'(rem);
            end
            WR_F_HDR: begin
                waddr = r_loc[AW-1:0];
                wdata = TW'(r_size);
            end
            WR_F_FTR: begin
                waddr = AW'(r_loc + r_size - CW'(1));
                wdata = TW'(r_size);
            end
            default: begin
                waddr = r_clr;
                wdata = '0;
                we    = 1'b0;
            end
        endcase
    end

    ffbt_ram #(
        .WIDTH(TW),
        .DEPTH(POOL_WORDS)
    ) u_pool (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);
            if (i_cmd.out_load)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_fail <= 1'b0;
            r_loc  <= '0;
            r_head <= CW'(i_free_addr) - CW'(1);
            r_need <= rnd_len + CW'(2);
        end
        if (i_cmd.set_fail)  r_fail <= 1'b1;
        if (i_cmd.walk_step) r_loc  <= r_loc + size_rd;
        if (i_cmd.ld_size)   r_size <= size_rd;
        if (i_cmd.ld_free) begin
            r_loc  <= r_head;
            r_size <= size_rd;
        end
        if (i_cmd.add_next) r_size <= r_size + size_rd;
        if (i_cmd.add_prev) begin
            r_loc  <= r_head - size_rd;
            r_size <= r_size + size_rd;
        end
        if (i_cmd.out_load) begin
            r_pidx <= (!r_req && !r_fail) ? PIDX_W'(r_loc + CW'(1)) : '0;
            r_stat <= !r_req && r_fail;
        end
    end

    always_comb begin
        o_status.in_free  = i_req_type;
        o_status.clr_done = (r_clr == AW'(POOL_WORDS - 1));
        o_status.loc_end  = (r_loc >= POOL_C);
        o_status.tag_zero = (size_rd == '0);
        o_status.fits     = free_rd && (size_rd > r_need);
        o_status.over     = (r_loc + size_rd > POOL_C);
        o_status.addr_bad = (r_head >= POOL_C);
        o_status.head_bad = (size_rd == '0) || (r_head + size_rd > POOL_C);
        o_status.has_next = (head_end < POOL_C);
        o_status.next_ok  = free_rd && (head_end + size_rd <= POOL_C);
        o_status.has_prev = (r_head != '0);
        o_status.prev_ok  = free_rd && (size_rd != '0) && (size_rd <= r_head);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_index = r_pidx;
    assign o_out_status    = r_stat;

endmodule

>>> src/first_fit_boundary_tag_allocator_unit.sv
// top level of the first-fit boundary-tag word pool allocator
//
//  channel | dir | tdata                              | tuser
//  s_*     | in  | [7:0] alloc_len, [15:8] free_addr  | [0] req_type
//  m_*     | out | [7:0] payload_index               | [0] status
//
// one request at a time; s_tready is high only while the controller is idle
// allocate: a tag read and a check per block visited, 4 tag writes, then the result is
// loaded and the controller returns to idle; a failed walk skips the tag writes
// free: head, next and previous tag reads, then two tag writes
// after reset a clearing pass writes the pool before s_tready rises
// a result holds in the output register until m_tready; one beat may wait there
module first_fit_boundary_tag_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] alloc_len, [15:8] free_addr
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] payload_index
    output logic [0:0]  m_tuser    // [0] status
);
    import ffbt_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    out_stat;

    ffbt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_tvalid),
        .i_status  (status),
        .o_in_ready(s_tready),
        .o_cmd     (cmd)
    );

    ffbt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (s_tuser[0]),
        .i_alloc_len    (s_tdata[7:0]),
        .i_free_addr    (s_tdata[15:8]),
        .i_out_ready    (m_tready),
        .o_status       (status),
        .o_out_valid    (m_tvalid),
        .o_payload_index(m_tdata),
        .o_out_status   (out_stat)
    );

    assign m_tuser = out_stat;

endmodule

>>> test/testbench.sv
// testbench for the first-fit boundary-tag allocator: directed and random alloc/free traffic
`timescale 1ns / 1ps

module testbench;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_FREE    = 1'b1;
    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;
    localparam int   POOL        = ffbt_pkg::POOL_WORDS;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [7:0] pidx;
        logic       status;
    } t_alloc_reply;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] alloc_len, [15:8] free_addr
    logic [0:0]  s_tuser  = '0;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] payload_index
    logic [0:0]  m_tuser;         // [0] status

    logic [8:0]   pool_tags [POOL];
    t_alloc_reply pending_replies [$];
    logic [7:0]   live_blocks [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           burst_left     = 1;
    bit           valid_high     = 1'b0;
    int           ready_pct      = 100;
    int           ready_left     = 0;

    first_fit_boundary_tag_allocator_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void write_tags(input int start, input int size, input bit used);
        if (size == 0 || start + size > POOL) return;
        pool_tags[start]            = 9'(size | int'(used));
        pool_tags[start + size - 1] = 9'(size | int'(used));
    endfunction

    function automatic void predict_request(input logic rtype, input logic [7:0] len,
                                            input logic [7:0] addr,
                                            output logic [7:0] pidx, output logic st);
        int  loc, tag, size, need, head, hlen, start, total, ntag, nsize, ptag, psize;
        bit  stop;
        pidx = '0;
        st   = ST_DONE;
        if (rtype == REQ_ALLOC) begin
            need = ((int'(len) + 3) & ~3) + 2;
            loc  = 0;
            stop = 1'b0;
            st   = ST_NO_SPACE;
            while (loc < POOL && !stop) begin
                tag  = int'(pool_tags[loc]);
                size = tag & ~1;
                if (size == 0) begin
                    stop = 1'b1;
                end else if ((tag & 1) == 0 && size > need) begin
                    stop = 1'b1;
                    if (loc + size <= POOL) begin
                        write_tags(loc, need, 1'b1);
                        write_tags(loc + need, size - need, 1'b0);
                        pidx = 8'(loc + 1);
                        st   = ST_DONE;
                    end
                end else begin
                    loc += size;
                end
            end
        end else if (addr != 0) begin
            head = int'(addr) - 1;
            hlen = int'(pool_tags[head]) & ~1;
            if (hlen != 0 && head + hlen <= POOL) begin
                start = head;
                total = hlen;
                if (head + hlen < POOL) begin
                    ntag  = int'(pool_tags[head + hlen]);
                    nsize = ntag & ~1;
                    if ((ntag & 1) == 0 && head + hlen + nsize <= POOL) total += nsize;
                end
                if (head > 0) begin
                    ptag  = int'(pool_tags[head - 1]);
                    psize = ptag & ~1;
                    if ((ptag & 1) == 0 && psize != 0 && psize <= head) begin
                        start = head - psize;
                        total += psize;
                    end
                end
                write_tags(start, total, 1'b0);
            end
        end
    endfunction

    task automatic send_req(input logic rtype, input logic [7:0] len, input logic [7:0] addr,
                            output logic [7:0] pidx, output logic st);
        int gap;
        predict_request(rtype, len, addr, pidx, st);
        pending_replies.push_back('{pidx: pidx, status: st});
        if (rtype == REQ_ALLOC && st == ST_DONE) live_blocks.push_back(pidx);
        if (rtype == REQ_FREE) begin
            for (int i = live_blocks.size() - 1; i >= 0; i--)
                if (live_blocks[i] == addr) live_blocks.delete(i);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {addr, len};
        s_tuser    <= rtype;
        valid_high = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid   <= 1'b0;
                valid_high = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_alloc_extremes();
        logic [7:0] pidx;
        logic       st;
        send_req(REQ_ALLOC, 8'd0,   8'($urandom), pidx, st);
        send_req(REQ_ALLOC, 8'd255, 8'($urandom), pidx, st);
        send_req(REQ_ALLOC, 8'd1,   8'($urandom), pidx, st);
        send_req(REQ_ALLOC, 8'd3,   8'($urandom), pidx, st);
        send_req(REQ_ALLOC, 8'd4,   8'($urandom), pidx, st);
        send_req(REQ_ALLOC, 8'd5,   8'($urandom), pidx, st);
        send_req(REQ_ALLOC, 8'd253, 8'($urandom), pidx, st);
        send_req(REQ_FREE,  8'd255, 8'd0,         pidx, st);
        send_req(REQ_FREE,  8'd0,   8'd255,       pidx, st);
    endtask

    task automatic test_free_merge();
        logic [7:0] pidx, a, b, c;
        logic       st;
        int         tries;
        send_req(REQ_ALLOC, 8'd8, 8'hAA, a, st);
        send_req(REQ_ALLOC, 8'd8, 8'h55, b, st);
        send_req(REQ_ALLOC, 8'd8, 8'($urandom), c, st);
        send_req(REQ_FREE, 8'h55, b, pidx, st);
        send_req(REQ_FREE, 8'hAA, a, pidx, st);
        send_req(REQ_FREE, 8'($urandom), c, pidx, st);
        // already free, then a stale header word
        send_req(REQ_FREE, 8'($urandom), c, pidx, st);
        send_req(REQ_FREE, 8'($urandom), 8'(c + 8'd10), pidx, st);
        tries = 0;
        st    = ST_DONE;
        while (st == ST_DONE && tries < 6) begin
            send_req(REQ_ALLOC, 8'd60, 8'($urandom), pidx, st);
            tries++;
        end
        while (live_blocks.size() != 0)
            send_req(REQ_FREE, 8'($urandom),
                     live_blocks[$urandom_range(0, live_blocks.size() - 1)], pidx, st);
    endtask

    task automatic test_random_traffic(input int n_items, input int alloc_pct);
        logic [7:0] len, addr, pidx;
        logic       st;
        int         r;
        for (int k = 0; k < n_items; k++) begin
            r    = $urandom_range(0, 99);
            len  = 8'($urandom);
            addr = 8'($urandom);
            if (r < 6) begin
                // noise: raw requests with any field values
                send_req($urandom_range(0, 1) ? REQ_FREE : REQ_ALLOC, len, addr, pidx, st);
            end else if (live_blocks.size() == 0 || r < 6 + alloc_pct) begin
                r = $urandom_range(0, 19);
                if (r < 15)      len = 8'($urandom_range(0, 24));
                else if (r < 19) len = 8'($urandom_range(25, 120));
                send_req(REQ_ALLOC, len, addr, pidx, st);
            end else begin
                addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                send_req(REQ_FREE, len, addr, pidx, st);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_pct  <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(5, 95);
            ready_left <= $urandom_range(8, 64);
        end else begin
            ready_left <= ready_left - 1;
        end
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge i_clk) begin
        t_alloc_reply exp_reply;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual pidx %0d status %0d",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                exp_reply = pending_replies.pop_front();
                if (m_tdata !== exp_reply.pidx) begin
                    $display("%0t: payload_index expected %0d actual %0d",
                             $time, exp_reply.pidx, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== exp_reply.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_reply.status, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("first_fit_boundary_tag_allocator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < POOL; i++) pool_tags[i] = '0;
        write_tags(0, POOL, 1'b0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alloc_extremes();
        test_free_merge();
        test_random_traffic(450, 55);
        test_random_traffic(450, 35);
        test_random_traffic(450, 45);
        if (valid_high) s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("first_fit_boundary_tag_allocator_unit: match");
        end else begin
            $display("first_fit_boundary_tag_allocator_unit: mismatch");
        end
        $finish;
    end

endmodule
